// ===== design/labeled_mailbox_slots_core_macros.svh =====
// Assertion macros shared by the mailbox slot table RTL.
// Include with the bare file name; define ASSERT_OFF to drop every check.
`ifndef LABELED_MAILBOX_SLOTS_CORE_MACROS_SVH
`define LABELED_MAILBOX_SLOTS_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// General property check, clocked and disabled while reset is active.
`define LMS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be observed at a clock edge.
`define LMS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LMS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/lms_pkg.sv =====
// Types and constants for the mailbox slot table.
// No dependencies; used by every module.
package lms_pkg;

	localparam int unsigned LABEL_W = 6;
	localparam int unsigned TYPE_W  = 16;
	localparam int unsigned PARAM_W = 32;
	localparam int unsigned OCC_W   = 5;

	// Label value that names no receiver; posts and label requests with it are refused.
	localparam logic [7:0] EMPTY_LABEL = 8'd63;
	localparam logic [LABEL_W-1:0] NONE_LABEL = EMPTY_LABEL[LABEL_W-1:0];

	localparam logic [2:0] KIND_POST        = 3'd0;
	localparam logic [2:0] KIND_TAKE_ANY    = 3'd1;
	localparam logic [2:0] KIND_TAKE_LABEL  = 3'd2;
	localparam logic [2:0] KIND_CLEAR_LABEL = 3'd3;
	localparam logic [2:0] KIND_CLEAR_ALL   = 3'd4;

	typedef struct packed {
		logic [2:0]         kind;
		logic [LABEL_W-1:0] label;
		logic [TYPE_W-1:0]  mail_type;
		logic [PARAM_W-1:0] param_word;
	} lms_req_t;

	typedef struct packed {
		logic               ok;
		logic [LABEL_W-1:0] got_label;
		logic [TYPE_W-1:0]  got_type;
		logic [PARAM_W-1:0] got_param;
		logic [OCC_W-1:0]   occupied;
	} lms_rsp_t;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic [TYPE_W-1:0]  mail_type;
		logic [PARAM_W-1:0] param_word;
	} lms_entry_t;

	// Sequencer status toward the response stage.
	typedef struct packed {
		logic idle;
		logic done;
	} lms_seq_stat_t;

	function automatic logic is_empty_label(input logic [LABEL_W-1:0] lbl);
		return {2'b00, lbl} == EMPTY_LABEL;
	endfunction

endpackage

// ===== design/lms_chan_if.sv =====
// Valid/ready channel carrying one request or response payload.
// Payload type is chosen at instantiation (lms_pkg request or response struct).
interface lms_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/lms_slot_mem.sv =====
// Slot contents store: one write port, one read port with registered data.
// Depends on lms_pkg for the entry type.
module lms_slot_mem #(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  lms_pkg::lms_entry_t wr_data,
	input  logic [AW-1:0]       rd_addr,
	output lms_pkg::lms_entry_t rd_data
);

	lms_pkg::lms_entry_t mem_q [DEPTH];
	lms_pkg::lms_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/lms_seq.sv =====
// Scan sequencer: slot valid bits, occupied count and the shared slot compare.
// Depends on lms_pkg and the assertion macros; drives the lms_slot_mem ports.
`include "labeled_mailbox_slots_core_macros.svh"

module lms_seq #(
	parameter int unsigned SLOTS = 16,
	localparam int unsigned AW = $clog2(SLOTS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  lms_pkg::lms_req_t      req,
	input  logic                   ack,
	output lms_pkg::lms_seq_stat_t stat,
	output lms_pkg::lms_rsp_t      res,
	output logic                   wr_en,
	output logic [AW-1:0]          wr_addr,
	output lms_pkg::lms_entry_t    wr_data,
	output logic [AW-1:0]          rd_addr,
	input  lms_pkg::lms_entry_t    rd_data
);

	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam int unsigned IW = AW + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	state_t            state_q;
	lms_pkg::lms_req_t op_q;
	lms_pkg::lms_rsp_t res_q;
	logic [SLOTS-1:0]  valid_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     iss_q;
	logic              chk_vld_s1;
	logic [AW-1:0]     chk_idx_s1;

	logic is_post;
	logic is_any;
	logic is_clr;
	logic slot_vld;
	logic hit;
	logic last;
	logic issue;
	logic finish;
	logic needs_scan;

	assign is_post  = op_q.kind == lms_pkg::KIND_POST;
	assign is_any   = op_q.kind == lms_pkg::KIND_TAKE_ANY;
	assign is_clr   = op_q.kind == lms_pkg::KIND_CLEAR_LABEL;
	assign slot_vld = valid_q[chk_idx_s1];

	// Shared compare: free slot for a post, occupied (and label match unless take-any) otherwise.
	assign hit = chk_vld_s1 && (is_post ? !slot_vld
		: (slot_vld && (is_any || (rd_data.label == op_q.label))));
	assign last   = chk_vld_s1 && (chk_idx_s1 == AW'(SLOTS - 1));
	assign issue  = (state_q == ST_SCAN) && (iss_q < IW'(SLOTS));
	assign finish = hit ? (!is_clr || last) : last;

	always_comb begin
		case (req.kind)
			lms_pkg::KIND_POST: begin
				needs_scan = (req.mail_type != '0) && !lms_pkg::is_empty_label(req.label);
			end
			lms_pkg::KIND_TAKE_ANY: begin
				needs_scan = 1'b1;
			end
			lms_pkg::KIND_TAKE_LABEL, lms_pkg::KIND_CLEAR_LABEL: begin
				needs_scan = !lms_pkg::is_empty_label(req.label);
			end
			default: begin
				needs_scan = 1'b0;
			end
		endcase
	end

	assign rd_addr = iss_q[AW-1:0];
	assign wr_en   = (state_q == ST_SCAN) && hit && is_post;
	assign wr_addr = chk_idx_s1;
	assign wr_data = '{label: op_q.label, mail_type: op_q.mail_type,
		param_word: op_q.param_word};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= '0;
			res_q      <= '0;
			valid_q    <= '0;
			count_q    <= '0;
			iss_q      <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q       <= req;
						iss_q      <= '0;
						chk_vld_s1 <= 1'b0;
						res_q      <= '{ok: 1'b0, got_label: lms_pkg::NONE_LABEL,
							got_type: '0, got_param: '0,
							occupied: (req.kind == lms_pkg::KIND_CLEAR_ALL) ?
								{lms_pkg::OCC_W{1'b0}} : lms_pkg::OCC_W'(count_q)};
						if (req.kind == lms_pkg::KIND_CLEAR_ALL) begin
							valid_q <= '0;
							count_q <= '0;
							state_q <= ST_DONE;
						end else if (needs_scan) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					chk_vld_s1 <= issue && !finish;
					chk_idx_s1 <= iss_q[AW-1:0];
					if (issue) begin
						iss_q <= iss_q + IW'(1);
					end
					if (hit) begin
						if (is_post) begin
							valid_q[chk_idx_s1] <= 1'b1;
							count_q             <= count_q + CW'(1);
							res_q.ok            <= 1'b1;
							res_q.occupied      <= lms_pkg::OCC_W'(count_q + CW'(1));
						end else begin
							valid_q[chk_idx_s1] <= 1'b0;
							count_q             <= count_q - CW'(1);
							res_q.occupied      <= lms_pkg::OCC_W'(count_q - CW'(1));
							if (!is_clr) begin
								res_q.ok        <= 1'b1;
								res_q.got_label <= rd_data.label;
								res_q.got_type  <= rd_data.mail_type;
								res_q.got_param <= rd_data.param_word;
							end
						end
					end
					if (finish) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat = '{idle: state_q == ST_IDLE, done: state_q == ST_DONE};
	assign res  = res_q;

	`LMS_ASSERT(a_count_tracks_valid, clk, arst_n, count_q == CW'($countones(valid_q)), "count off")
	`LMS_ASSERT(a_post_counts_up, clk, arst_n, wr_en |=> count_q == $past(count_q) + CW'(1), "no count up")
	`LMS_ASSERT(a_write_only_post, clk, arst_n, wr_en |-> is_post, "slot write outside a post")
	`LMS_ASSERT_NEVER(a_check_outside_scan, clk, arst_n, chk_vld_s1 && (state_q != ST_SCAN), "stray compare")

endmodule

// ===== design/labeled_mailbox_slots_core.sv =====
// Mailbox slot table top level: request/response channels and response register.
// Depends on lms_pkg, lms_chan_if, lms_slot_mem and lms_seq.
//
// A table of SLOTS message slots, each holding a receiver label, a message type
// and a parameter word; label 63 names no receiver. A request (kind) posts into
// the lowest free slot, takes the lowest occupied slot, takes the lowest slot of
// a given label, clears every slot of a label, or clears the table; each request
// yields exactly one response with ok, the taken message and the occupied count.
// Requests are handled one at a time. A request that needs the table is scanned
// one slot per cycle through the single read port of the slot memory; a post
// or a take stops early at its hit. Clear-all, unknown kinds and requests that
// are refused on sight skip the scan. Slot occupancy lives in flip-flops that
// reset clears at once, so no clearing pass follows reset. A finished response
// waits in an output register, and the next request is taken while it waits.
module labeled_mailbox_slots_core #(
	parameter int unsigned SLOTS = 16
) (
	input logic         clk,
	input logic         arst_n,
	lms_chan_if.sink    req,
	lms_chan_if.source  rsp
);

	localparam int unsigned AW = $clog2(SLOTS);

	lms_pkg::lms_seq_stat_t stat;
	lms_pkg::lms_rsp_t      res;
	lms_pkg::lms_rsp_t      rsp_q;
	lms_pkg::lms_entry_t    wr_data;
	lms_pkg::lms_entry_t    rd_data;
	logic                   rsp_vld_q;
	logic                   start;
	logic                   ack;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr;

	// Take a request only while the sequencer is idle.
	assign req.ready = stat.idle;
	assign start     = req.valid && stat.idle;

	// Move a finished response into the output register when it is free or draining.
	assign ack = stat.done && (!rsp_vld_q || rsp.ready);

	lms_slot_mem #(.DEPTH(SLOTS)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lms_seq #(.SLOTS(SLOTS)) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req.payload),
		.ack     (ack),
		.stat    (stat),
		.res     (res),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Hold the response until the sink takes it; load the next one behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
			rsp_q     <= '0;
		end else if (ack) begin
			rsp_vld_q <= 1'b1;
			rsp_q     <= res;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	assign rsp.valid   = rsp_vld_q;
	assign rsp.payload = rsp_q;

endmodule
